/* sv/svpwm_pkg.sv */
// Shared types, widths and constants of the three-channel servo pulse generator.
package svpwm_pkg;

  localparam int unsigned PIN_COUNT        = 3;
  localparam int unsigned DEF_NUM_CHANNELS = 3;

  localparam int unsigned CNT_W   = 20;
  localparam int unsigned TPU_W   = 6;
  localparam int unsigned CMP_W   = 18;
  localparam int unsigned BASE_W  = 12;
  localparam int unsigned ANGLE_W = 8;
  localparam int unsigned MAG_W   = 7;
  localparam int unsigned Q_W     = 10;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam int unsigned ANGLE_LIM = 90;
  localparam int unsigned BASE_MID  = 1500;
  localparam int unsigned BASE_ON   = 2500;

  // Just above 100/9 scaled by 2^19; exact truncation for magnitudes up to 90
  localparam int unsigned RECIP_W  = 23;
  localparam int unsigned RECIP    = 5825500;
  localparam int unsigned RECIP_SH = 19;

  localparam int unsigned PERIOD_RST = 500000;
  localparam int unsigned TPU_RST    = 25;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_TPU    = 1'b1;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_ON   = 2'd1,
    REQ_MOVE = 2'd2,
    REQ_OFF  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TICK,
    OP_ON,
    OP_MOVE,
    OP_OFF
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [PIN_COUNT-1:0] sel;
    logic [BASE_W-1:0]    base;
  } op_t;

  function automatic int unsigned lane_count(int unsigned num_channels);
    return (num_channels < PIN_COUNT) ? num_channels : PIN_COUNT;
  endfunction

endpackage

/* sv/svpwm_front.sv */
// Front end: decodes requests, checks the channel and turns the angle into a base pulse width.
module svpwm_front import svpwm_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  logic                      [1:0] req_type_i,
  input  logic                      [1:0] channel_i,
  input  logic signed [ANGLE_W-1:0]       angle_i,
  output op_t                             op_o
);

  localparam int unsigned LaneCnt = lane_count(NUM_CHANNELS);
  localparam int unsigned PROD_W  = MAG_W + RECIP_W;

  logic [PIN_COUNT-1:0] sel;
  logic                 neg;
  logic [MAG_W-1:0]     mag;
  logic [PROD_W-1:0]    prod;
  logic [Q_W-1:0]       q;
  logic [BASE_W-1:0]    move_base;

  always_comb begin
    for (int i = 0; i < PIN_COUNT; i++) begin
      sel[i] = (i < LaneCnt) && (channel_i == 2'(i));
    end
  end

  always_comb begin
    neg = angle_i[ANGLE_W-1];
    if (angle_i < -$signed(ANGLE_W'(ANGLE_LIM)) || angle_i > $signed(ANGLE_W'(ANGLE_LIM))) begin
      mag = MAG_W'(ANGLE_LIM);
    end else if (neg) begin
      mag = MAG_W'(-angle_i);
    end else begin
      mag = MAG_W'(angle_i);
    end
  end

  assign prod = PROD_W'(mag) * PROD_W'(RECIP);
  assign q    = prod[RECIP_SH +: Q_W];

  assign move_base = neg ? (BASE_W'(BASE_MID) + BASE_W'(q))
                         : (BASE_W'(BASE_MID) - BASE_W'(q));

  always_comb begin
    op_o.sel  = sel;
    op_o.base = move_base;
    op_o.op   = OP_NONE;
    case (req_e'(req_type_i))
      REQ_TICK: op_o.op = OP_TICK;
      REQ_ON: begin
        op_o.base = BASE_W'(BASE_ON);
        if (|sel) op_o.op = OP_ON;
      end
      REQ_MOVE: if (|sel) op_o.op = OP_MOVE;
      REQ_OFF:  if (|sel) op_o.op = OP_OFF;
      default:  op_o.op = OP_NONE;
    endcase
  end

endmodule

/* sv/svpwm_fifo.sv */
// Short queue of decoded operations between the front end and the back end.
module svpwm_fifo import svpwm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_data_i,
  output logic full_o,
  output logic head_valid_o,
  output op_t  head_o,
  input  logic pop_i
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  op_t             mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

/* sv/svpwm_back.sv */
// Back end: tick counter, per-channel compare and pin state, and the result register.
module svpwm_back import svpwm_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [CNT_W-1:0]                      period_i,
  input  logic [TPU_W-1:0]                      tpu_i,
  input  logic                                  head_valid_i,
  input  op_t                                   head_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [lane_count(NUM_CHANNELS)-1:0]   pins_o,
  output logic                                  move_ok_o
);

  localparam int unsigned LaneCnt = lane_count(NUM_CHANNELS);

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W:0]     cnt_inc;
  logic [LaneCnt-1:0] en_q, en_d;
  logic [LaneCnt-1:0] pin_q, pin_d;
  logic [LaneCnt-1:0] cmp_we;
  logic [CMP_W-1:0]   cmp_q [LaneCnt];
  logic [CMP_W-1:0]   cmp_new;
  logic               ok_q, ok_d;
  logic               valid_q, valid_d;

  assign pop_o   = head_valid_i && (!valid_q || !out_stall_i);
  assign cmp_new = CMP_W'(head_i.base) * CMP_W'(tpu_i);
  assign cnt_inc = (CNT_W + 1)'(cnt_q) + 1'b1;

  always_comb begin
    cnt_d   = cnt_q;
    en_d    = en_q;
    pin_d   = pin_q;
    cmp_we  = '0;
    ok_d    = ok_q;
    valid_d = valid_q && out_stall_i;
    if (pop_o) begin
      valid_d = 1'b1;
      ok_d    = 1'b0;
      case (head_i.op)
        OP_TICK: begin
          for (int i = 0; i < LaneCnt; i++) begin
            if (en_q[i]) begin
              if (cnt_q == '0) pin_d[i] = 1'b0;
              if (CNT_W'(cmp_q[i]) == cnt_q) pin_d[i] = 1'b1;
            end
          end
          cnt_d = (cnt_inc >= (CNT_W + 1)'(period_i)) ? '0 : cnt_inc[CNT_W-1:0];
        end
        OP_ON: begin
          for (int i = 0; i < LaneCnt; i++) begin
            if (head_i.sel[i]) begin
              en_d[i]   = 1'b1;
              pin_d[i]  = 1'b1;
              cmp_we[i] = 1'b1;
            end
          end
        end
        OP_MOVE: begin
          for (int i = 0; i < LaneCnt; i++) begin
            if (head_i.sel[i] && en_q[i]) begin
              cmp_we[i] = 1'b1;
              ok_d      = 1'b1;
            end
          end
        end
        OP_OFF: begin
          for (int i = 0; i < LaneCnt; i++) begin
            if (head_i.sel[i]) begin
              en_d[i]  = 1'b0;
              pin_d[i] = 1'b1;
            end
          end
        end
        default: ok_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      en_q    <= '0;
      pin_q   <= '1;
      ok_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      en_q    <= en_d;
      pin_q   <= pin_d;
      ok_q    <= ok_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LaneCnt; i++) begin
      if (cmp_we[i]) cmp_q[i] <= cmp_new;
    end
  end

  assign out_valid_o = valid_q;
  assign pins_o      = pin_q;
  assign move_ok_o   = ok_q;

endmodule

/* sv/servo_pwm_generator_3ch.sv */
// Throughput: one item per cycle while the output does not stall; the back end
// retires one queued operation per cycle, limited by the single update of the tick
// counter and channel state.
// Input stalls only when the two-entry queue is full; output is one register deep.
// Reset: counter zero, all channels disabled, all pins high, period 500000, 25 ticks/us.
module servo_pwm_generator_3ch import svpwm_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic               [1:0]  req_type_i,
  input  logic               [1:0]  channel_i,
  input  logic signed [ANGLE_W-1:0] angle_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      pin_a_o,
  output logic                      pin_b_o,
  output logic                      pin_c_o,
  output logic                      move_ok_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  localparam int unsigned LaneCnt = lane_count(NUM_CHANNELS);

  logic [CNT_W-1:0]     period_q;
  logic [TPU_W-1:0]     tpu_q;
  logic                 cfg_wr;
  op_t                  front_op;
  op_t                  head;
  logic                 head_valid;
  logic                 pop;
  logic                 q_full;
  logic [LaneCnt-1:0]   pins;
  logic [PIN_COUNT-1:0] pin_all;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= CNT_W'(PERIOD_RST);
      tpu_q    <= TPU_W'(TPU_RST);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_PERIOD) period_q <= pwdata[CNT_W-1:0];
      else tpu_q <= pwdata[TPU_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_TPU) ? DATA_W'(tpu_q) : DATA_W'(period_q);

  svpwm_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .req_type_i(req_type_i),
    .channel_i (channel_i),
    .angle_i   (angle_i),
    .op_o      (front_op)
  );

  assign in_stall_o = q_full;

  svpwm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_op),
    .full_o      (q_full),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  svpwm_back #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .period_i    (period_q),
    .tpu_i       (tpu_q),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pins_o      (pins),
    .move_ok_o   (move_ok_o)
  );

  for (genvar g = 0; g < PIN_COUNT; g++) begin : g_pin
    if (g < LaneCnt) begin : g_live
      assign pin_all[g] = pins[g];
    end else begin : g_absent
      assign pin_all[g] = 1'b1;
    end
  end

  assign pin_a_o = pin_all[0];
  assign pin_b_o = pin_all[1];
  assign pin_c_o = pin_all[2];

endmodule

/* dv/tb_servo_pwm_generator_3ch.sv */
// Self-checking testbench for the three-channel servo pulse generator with a per-item predictor.
module tb_servo_pwm_generator_3ch;
  import svpwm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] BAD_CHAN = 2'd3;

  typedef struct packed {
    req_e                      req;
    logic [1:0]                chan;
    logic signed [ANGLE_W-1:0] angle;
  } servo_cmd_t;

  typedef struct packed {
    logic                 move_ok;
    logic [PIN_COUNT-1:0] pins;
  } servo_levels_t;

  logic                      clk_i;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic [1:0]                req_type_i  = '0;
  logic [1:0]                channel_i   = '0;
  logic signed [ANGLE_W-1:0] angle_i     = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic                      pin_a_o;
  logic                      pin_b_o;
  logic                      pin_c_o;
  logic                      move_ok_o;
  logic                      psel        = 1'b0;
  logic                      penable     = 1'b0;
  logic                      pwrite      = 1'b0;
  logic [ADDR_W-1:0]         paddr       = '0;
  logic [DATA_W-1:0]         pwdata      = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  servo_pwm_generator_3ch dut (.*);

  // predictor state and its copy of the registers
  logic [CNT_W-1:0]     period_reg;
  logic [TPU_W-1:0]     tpu_reg;
  logic [CNT_W-1:0]     frame_count;
  logic [CMP_W-1:0]     pulse_cmp [PIN_COUNT];
  logic [PIN_COUNT-1:0] chan_on;
  logic [PIN_COUNT-1:0] pin_level;

  servo_cmd_t    servo_cmds [$];
  servo_levels_t pending_levels [$];
  servo_cmd_t    cur_cmd;
  servo_levels_t want;

  int unsigned queued_items = 0;
  int unsigned taken_items  = 0;
  int unsigned tick_items   = 0;
  int unsigned checked      = 0;
  int unsigned moves_ok     = 0;
  int unsigned err_count    = 0;
  int unsigned burst_left   = 0;
  int unsigned gap_left     = 0;
  int unsigned rx_cycle     = 0;
  int unsigned hold_left    = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [CMP_W-1:0] pulse_ticks(int deg);
    int lim;
    int q;
    lim = ANGLE_LIM;
    if (deg < -lim) deg = -lim;
    if (deg > lim) deg = lim;
    q = (2000 * deg) / 180;
    return CMP_W'((BASE_MID - q) * int'(tpu_reg));
  endfunction

  function automatic servo_levels_t advance_servo(servo_cmd_t c);
    servo_levels_t r;
    r.move_ok = 1'b0;
    if (c.req == REQ_TICK) begin
      for (int i = 0; i < PIN_COUNT; i++) begin
        if (chan_on[i] && frame_count == '0) pin_level[i] = 1'b0;
        if (chan_on[i] && pulse_cmp[i] == CMP_W'(frame_count)
            && frame_count < (1 << CMP_W)) pin_level[i] = 1'b1;
      end
      if (int'(frame_count) + 1 >= int'(period_reg)) frame_count = '0;
      else frame_count = frame_count + 1'b1;
    end else if (c.chan < PIN_COUNT && c.chan < DEF_NUM_CHANNELS) begin
      case (c.req)
        REQ_ON: begin
          pin_level[c.chan] = 1'b1;
          pulse_cmp[c.chan] = pulse_ticks(-int'(ANGLE_LIM));
          chan_on[c.chan] = 1'b1;
        end
        REQ_MOVE: begin
          if (chan_on[c.chan]) begin
            pulse_cmp[c.chan] = pulse_ticks(int'(c.angle));
            r.move_ok = 1'b1;
          end
        end
        default: begin
          chan_on[c.chan] = 1'b0;
          pin_level[c.chan] = 1'b1;
        end
      endcase
    end
    r.pins = pin_level;
    return r;
  endfunction

  function automatic servo_cmd_t mk_cmd(req_e r, logic [1:0] ch, int a);
    servo_cmd_t c;
    c.req = r;
    c.chan = ch;
    c.angle = ANGLE_W'(a);
    return c;
  endfunction

  function automatic servo_cmd_t rand_cmd(int unsigned tick_pct, bit short_pulse);
    servo_cmd_t c;
    int unsigned pick;
    c.chan = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 6);
    if (short_pulse) c.angle = ANGLE_W'($urandom_range(45, 127));
    else if ($urandom_range(0, 3) == 0)
      c.angle = (pick == 0) ? -8'sd128 : (pick == 1) ? -8'sd91 : (pick == 2) ? -8'sd90 :
                (pick == 3) ? 8'sd90 : (pick == 4) ? 8'sd91 : (pick == 5) ? 8'sd127 : 8'sd0;
    else c.angle = ANGLE_W'($urandom());
    if ($urandom_range(0, 99) < tick_pct) c.req = REQ_TICK;
    else begin
      pick = $urandom_range(0, 9);
      c.req = (pick < 3) ? REQ_ON : (pick < 8) ? REQ_MOVE : REQ_OFF;
    end
    return c;
  endfunction

  function automatic void queue_cmd(servo_cmd_t c);
    servo_cmds.push_back(c);
    queued_items++;
  endfunction

  function automatic void check_bit(string name, logic exp_v, logic got_v);
    if (got_v !== exp_v) begin
      err_count++;
      $display("%0t ns: result %0d %s expected %0b got %0b", $time, checked, name, exp_v, got_v);
    end
  endfunction

  task automatic wait_quiet();
    while (taken_items != queued_items || pending_levels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [DATA_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_PERIOD) period_reg = val[CNT_W-1:0];
    else tpu_reg = val[TPU_W-1:0];
  endtask

  // sender: bursts of items with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      req_type_i <= '0;
      channel_i  <= '0;
      angle_i    <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        pending_levels.push_back(advance_servo(cur_cmd));
        if (cur_cmd.req == REQ_TICK) tick_items++;
        taken_items++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0 || servo_cmds.size() == 0) begin
          in_valid_i <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          cur_cmd = servo_cmds.pop_front();
          req_type_i <= cur_cmd.req;
          channel_i  <= cur_cmd.chan;
          angle_i    <= cur_cmd.angle;
          in_valid_i <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // receiver: rotating stall pattern plus a periodic long hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_left == 0 && rx_cycle % 500 == 250) hold_left = 60;
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (rx_cycle[8:7])
          2'd0: out_stall_i <= 1'b0;
          2'd1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2'd2: out_stall_i <= rx_cycle[0];
          default: out_stall_i <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_levels.size() == 0) begin
        err_count++;
        $display("%0t ns: result with no item waiting, expected none got pins %0b%0b%0b ok %0b",
                 $time, pin_c_o, pin_b_o, pin_a_o, move_ok_o);
      end else begin
        want = pending_levels.pop_front();
        check_bit("pin_a", want.pins[0], pin_a_o);
        check_bit("pin_b", want.pins[1], pin_b_o);
        check_bit("pin_c", want.pins[2], pin_c_o);
        check_bit("move_ok", want.move_ok, move_ok_o);
        if (want.move_ok) moves_ok++;
      end
      checked++;
    end
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    period_reg  = PERIOD_RST;
    tpu_reg     = TPU_RST;
    frame_count = '0;
    chan_on     = '0;
    pin_level   = '1;
    for (int i = 0; i < PIN_COUNT; i++) pulse_cmp[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_cmd(mk_cmd(REQ_TICK, 2'd0, 0));
    queue_cmd(mk_cmd(REQ_MOVE, 2'd0, 0));
    queue_cmd(mk_cmd(REQ_ON, BAD_CHAN, 0));
    queue_cmd(mk_cmd(REQ_MOVE, BAD_CHAN, 10));
    queue_cmd(mk_cmd(REQ_OFF, BAD_CHAN, 0));
    queue_cmd(mk_cmd(REQ_ON, 2'd0, 55));
    queue_cmd(mk_cmd(REQ_ON, 2'd1, 0));
    queue_cmd(mk_cmd(REQ_ON, 2'd2, -1));
    queue_cmd(mk_cmd(REQ_MOVE, 2'd0, -128));
    queue_cmd(mk_cmd(REQ_MOVE, 2'd1, 127));
    queue_cmd(mk_cmd(REQ_MOVE, 2'd2, 91));
    queue_cmd(mk_cmd(REQ_MOVE, 2'd2, 90));
    queue_cmd(mk_cmd(REQ_MOVE, 2'd0, -90));
    queue_cmd(mk_cmd(REQ_MOVE, 2'd0, -91));
    queue_cmd(mk_cmd(REQ_MOVE, 2'd1, -1));
    queue_cmd(mk_cmd(REQ_MOVE, 2'd1, 1));
    queue_cmd(mk_cmd(REQ_MOVE, 2'd2, 0));
    queue_cmd(mk_cmd(REQ_TICK, BAD_CHAN, -128));
    queue_cmd(mk_cmd(REQ_OFF, 2'd1, 0));
    queue_cmd(mk_cmd(REQ_MOVE, 2'd1, 45));
    queue_cmd(mk_cmd(REQ_TICK, 2'd2, 127));
    wait_quiet();

    write_reg(REG_PERIOD, 2);
    write_reg(REG_TPU, 63);
    repeat (25) queue_cmd(rand_cmd(40, 1'b0));
    wait_quiet();

    write_reg(REG_PERIOD, 20'hFFFFF);
    write_reg(REG_TPU, 1);
    repeat (20) queue_cmd(rand_cmd(50, 1'b0));
    wait_quiet();

    // short frame so the counter wraps and reaches the compare points
    write_reg(REG_PERIOD, $urandom_range(505, 515));
    for (int ch = 0; ch < PIN_COUNT; ch++) begin
      queue_cmd(mk_cmd(REQ_ON, 2'(ch), 0));
      queue_cmd(mk_cmd(REQ_MOVE, 2'(ch), $urandom_range(45, 127)));
    end
    repeat (540) queue_cmd(rand_cmd(99, 1'b1));
    wait_quiet();

    write_reg(REG_PERIOD, $urandom_range(2, 50));
    write_reg(REG_TPU, $urandom_range(1, 63));
    repeat (25) queue_cmd(rand_cmd(60, 1'b0));
    wait_quiet();

    $display("Ran %0d items (%0d ticks, %0d accepted moves) across five register settings,",
             taken_items, tick_items, moves_ok);
    $display("including minimum and maximum frame length and pulse scale; %0d results compared.",
             checked);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

/* servo_pwm_generator_3ch.f */
sv/svpwm_pkg.sv
sv/svpwm_front.sv
sv/svpwm_fifo.sv
sv/svpwm_back.sv
sv/servo_pwm_generator_3ch.sv
dv/tb_servo_pwm_generator_3ch.sv
